// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers. The enclosing module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QAU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/qau_pkg.sv =====
`default_nettype none
package qau_pkg;

	localparam int WORD_BITS = 16;
	localparam int FRAC_BITS = 14;
	localparam int FRAC_MAX  = 30;
	// Wide enough for the 1.0 term at the largest fraction width plus carries.
	localparam int ACC_BITS  = 2 * FRAC_MAX + 6;
	localparam int PROD_BITS = 2 * WORD_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [ACC_BITS-1:0]  acc_t;

	typedef enum logic [1:0] {
		FUNC_MUL = 2'd0,
		FUNC_ROT = 2'd1,
		FUNC_MAT = 2'd2
	} func_t;

	localparam logic [1:0] ROW_LAST = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		word_t      a_w;
		word_t      a_x;
		word_t      a_y;
		word_t      a_z;
		word_t      b_w;
		word_t      b_x;
		word_t      b_y;
		word_t      b_z;
	} op_t;

	typedef struct packed {
		word_t res_w;
		word_t res_x;
		word_t res_y;
		word_t res_z;
		logic  last;
	} res_t;

	localparam acc_t SAT_MAX = acc_t'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
	localparam acc_t SAT_MIN = -SAT_MAX - acc_t'(1);

	function automatic acc_t ext(input prod_t p);
		return acc_t'(p);
	endfunction

	// Round to nearest, ties toward plus infinity, then saturate to a word.
	function automatic word_t round_sat(input acc_t acc, input int frac);
		acc_t half;
		acc_t r;
		half = '0;
		half[frac-1] = 1'b1;
		r = (acc + half) >>> frac;
		if (r > SAT_MAX) begin
			r = SAT_MAX;
		end else if (r < SAT_MIN) begin
			r = SAT_MIN;
		end
		return r[WORD_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/qau_hprod.sv =====
`default_nettype none
// Two-stage Hamilton product a * (b0, s*bv): products, then sums and rounding.
module qau_hprod #(
	parameter int FRAC = qau_pkg::FRAC_BITS
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire qau_pkg::word_t a [4],
	input  wire qau_pkg::word_t b [4],
	input  wire logic          conj_b,
	output qau_pkg::word_t     r [4]
);

	qau_pkg::prod_t p_s1 [4][4];
	logic           neg_s1;
	qau_pkg::acc_t  sv [4];
	qau_pkg::acc_t  c [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					p_s1[i][j] <= a[i] * b[j];
				end
			end
			neg_s1 <= conj_b;
		end
	end

	always_comb begin
		sv[0] = qau_pkg::ext(p_s1[1][1]) + qau_pkg::ext(p_s1[2][2]) + qau_pkg::ext(p_s1[3][3]);
		sv[1] = qau_pkg::ext(p_s1[0][1]) + qau_pkg::ext(p_s1[2][3]) - qau_pkg::ext(p_s1[3][2]);
		sv[2] = qau_pkg::ext(p_s1[0][2]) + qau_pkg::ext(p_s1[3][1]) - qau_pkg::ext(p_s1[1][3]);
		sv[3] = qau_pkg::ext(p_s1[0][3]) + qau_pkg::ext(p_s1[1][2]) - qau_pkg::ext(p_s1[2][1]);
		c[0] = neg_s1 ? qau_pkg::ext(p_s1[0][0]) + sv[0] : qau_pkg::ext(p_s1[0][0]) - sv[0];
		for (int i = 1; i < 4; i++) begin
			c[i] = neg_s1 ? qau_pkg::ext(p_s1[i][0]) - sv[i] : qau_pkg::ext(p_s1[i][0]) + sv[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				r[i] <= qau_pkg::round_sat(c[i], FRAC);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/qau_matrix.sv =====
`default_nettype none
// Two-stage rotation matrix of a quaternion: squares and cross products, then rows.
module qau_matrix #(
	parameter int FRAC = qau_pkg::FRAC_BITS
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire qau_pkg::word_t q [4],
	output qau_pkg::word_t     m [9]
);

	qau_pkg::prod_t xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, wy_s1, xz_s1, yz_s1, wx_s1;
	qau_pkg::acc_t  c [9];
	qau_pkg::acc_t  one;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= q[1] * q[1];
			yy_s1 <= q[2] * q[2];
			zz_s1 <= q[3] * q[3];
			xy_s1 <= q[1] * q[2];
			wz_s1 <= q[0] * q[3];
			wy_s1 <= q[0] * q[2];
			xz_s1 <= q[1] * q[3];
			yz_s1 <= q[2] * q[3];
			wx_s1 <= q[0] * q[1];
		end
	end

	always_comb begin
		one = '0;
		one[2*FRAC] = 1'b1;
		c[0] = one - ((qau_pkg::ext(yy_s1) + qau_pkg::ext(zz_s1)) <<< 1);
		c[1] = (qau_pkg::ext(xy_s1) - qau_pkg::ext(wz_s1)) <<< 1;
		c[2] = (qau_pkg::ext(wy_s1) + qau_pkg::ext(xz_s1)) <<< 1;
		c[3] = (qau_pkg::ext(xy_s1) + qau_pkg::ext(wz_s1)) <<< 1;
		c[4] = one - ((qau_pkg::ext(xx_s1) + qau_pkg::ext(zz_s1)) <<< 1);
		c[5] = (qau_pkg::ext(yz_s1) - qau_pkg::ext(wx_s1)) <<< 1;
		c[6] = (qau_pkg::ext(xz_s1) - qau_pkg::ext(wy_s1)) <<< 1;
		c[7] = (qau_pkg::ext(wx_s1) + qau_pkg::ext(yz_s1)) <<< 1;
		c[8] = one - ((qau_pkg::ext(xx_s1) + qau_pkg::ext(yy_s1)) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				m[i] <= qau_pkg::round_sat(c[i], FRAC);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/qau_outbuf.sv =====
`default_nettype none
`include "assert_macros.svh"
// Output register; sends matrix items as three rows.
module qau_outbuf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid,
	input  wire logic [1:0]    func,
	input  wire qau_pkg::word_t q [4],
	input  wire qau_pkg::word_t mat [9],
	output logic               adv,
	output logic               res_valid,
	input  wire logic          res_stall,
	output qau_pkg::res_t      res
);

	logic           valid_q;
	logic [1:0]     row_q;
	logic [1:0]     func_q;
	qau_pkg::word_t q_q [4];
	qau_pkg::word_t mat_q [9];
	logic           last;

	assign last      = (func_q != qau_pkg::FUNC_MAT) || (row_q == qau_pkg::ROW_LAST);
	assign adv       = !valid_q || (!res_stall && last);
	assign res_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			row_q   <= '0;
		end else if (adv) begin
			valid_q <= valid;
			row_q   <= '0;
		end else if (!res_stall) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_q <= func;
			q_q    <= q;
			mat_q  <= mat;
		end
	end

	always_comb begin
		res.last = last;
		if (func_q == qau_pkg::FUNC_MAT) begin
			res.res_w = '0;
			case (row_q)
				2'd0: begin
					res.res_x = mat_q[0];
					res.res_y = mat_q[1];
					res.res_z = mat_q[2];
				end
				2'd1: begin
					res.res_x = mat_q[3];
					res.res_y = mat_q[4];
					res.res_z = mat_q[5];
				end
				default: begin
					res.res_x = mat_q[6];
					res.res_y = mat_q[7];
					res.res_z = mat_q[8];
				end
			endcase
		end else begin
			res.res_w = q_q[0];
			res.res_x = q_q[1];
			res.res_y = q_q[2];
			res.res_z = q_q[3];
		end
	end

	`QAU_ASSERT_NXT(a_hold_row, valid_q && res_stall, valid_q && $stable(row_q), "row moved under stall")
	`QAU_ASSERT_IMP(a_single_row, valid_q && func_q != qau_pkg::FUNC_MAT, row_q == 2'd0, "row set on single result")
	`QAU_ASSERT_NXT(a_next_row, valid_q && !res_stall && !last, valid_q && row_q == $past(row_q) + 2'd1, "matrix row skipped")

endmodule
`default_nettype wire

// ===== hw/rtl/quaternion_arith_unit_top.sv =====
`default_nettype none
// Path: an operand passes through the registers of stages s1 to s4, then the output register.
// Throughput: one multiply or rotate item per cycle while res_stall is low; a
// matrix item holds the output register until its three rows are sent, which stalls the pipeline.
// Reset: arst_n clears the valid bits of all stages and the output register;
// the data path registers are not reset.
module quaternion_arith_unit_top #(
	parameter int FRAC_BITS = qau_pkg::FRAC_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	output logic               op_stall,
	input  wire qau_pkg::op_t  op,
	output logic               res_valid,
	input  wire logic          res_stall,
	output qau_pkg::res_t      res
);

	// The whole pipeline moves as one when the output register can take a new item.
	logic adv;
	logic op_ok;

	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic [1:0] func_s1, func_s2, func_s3, func_s4;
	qau_pkg::word_t a_in [4];
	qau_pkg::word_t b_in [4];
	qau_pkg::word_t a_s1 [4];
	qau_pkg::word_t a_s2 [4];
	qau_pkg::word_t t_s2 [4];
	qau_pkg::word_t t_s3 [4];
	qau_pkg::word_t t_s4 [4];
	qau_pkg::word_t r_s4 [4];
	qau_pkg::word_t mat_s2 [9];
	qau_pkg::word_t mat_s3 [9];
	qau_pkg::word_t mat_s4 [9];
	qau_pkg::word_t q_out [4];

	// The unused selector code leaves no result, so it never becomes valid.
	assign op_ok = (op.func == qau_pkg::FUNC_MUL) || (op.func == qau_pkg::FUNC_ROT) ||
		(op.func == qau_pkg::FUNC_MAT);
	assign op_stall = !adv;

	assign a_in[0] = op.a_w;
	assign a_in[1] = op.a_x;
	assign a_in[2] = op.a_y;
	assign a_in[3] = op.a_z;
	// For rotation the vector is the pure quaternion built from B's imaginary part.
	assign b_in[0] = (op.func == qau_pkg::FUNC_ROT) ? '0 : op.b_w;
	assign b_in[1] = op.b_x;
	assign b_in[2] = op.b_y;
	assign b_in[3] = op.b_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= op_valid && op_ok;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= op.func;
			func_s2 <= func_s1;
			func_s3 <= func_s2;
			func_s4 <= func_s3;
			a_s1    <= a_in;
			a_s2    <= a_s1;
			t_s3    <= t_s2;
			t_s4    <= t_s3;
			mat_s3  <= mat_s2;
			mat_s4  <= mat_s3;
		end
	end

	// First pass: A*B for multiply, T = A*v for rotate.
	qau_hprod #(.FRAC(FRAC_BITS)) u_pass1 (
		.clk   (clk),
		.en    (adv),
		.a     (a_in),
		.b     (b_in),
		.conj_b(1'b0),
		.r     (t_s2)
	);

	// Second pass: T*conj(A), with the conjugate folded into the term signs.
	qau_hprod #(.FRAC(FRAC_BITS)) u_pass2 (
		.clk   (clk),
		.en    (adv),
		.a     (t_s2),
		.b     (a_s2),
		.conj_b(1'b1),
		.r     (r_s4)
	);

	qau_matrix #(.FRAC(FRAC_BITS)) u_matrix (
		.clk(clk),
		.en (adv),
		.q  (a_in),
		.m  (mat_s2)
	);

	// Multiply returns the first pass; rotate returns the vector part of the second.
	always_comb begin
		if (func_s4 == qau_pkg::FUNC_MUL) begin
			q_out = t_s4;
		end else begin
			q_out[0] = '0;
			q_out[1] = r_s4[1];
			q_out[2] = r_s4[2];
			q_out[3] = r_s4[3];
		end
	end

	qau_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s4),
		.func     (func_s4),
		.q        (q_out),
		.mat      (mat_s4),
		.adv      (adv),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule
`default_nettype wire
